/* rtl/ptq_pkg.sv */
// Shared types and constants for the preemptive priority task queue.
// No dependencies; the other files, bar ptq_chan_if, use it by scoped names.
package ptq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NEST_DEPTH_DEF  = 16;

	localparam int ID_W    = 8;
	localparam int PRIO_W  = 8;
	localparam int RUN_W   = 9;
	localparam int COUNT_W = 5;

	// Running priority when no task runs: less urgent than any task
	localparam logic [RUN_W-1:0] IDLE_PRIORITY = RUN_W'(256);

	typedef enum logic [1:0] {
		FN_ADD      = 2'd0,
		FN_DISPATCH = 2'd1,
		FN_DONE     = 2'd2,
		FN_NONE     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_FULL        = 2'd1,
		ST_NO_DISPATCH = 2'd2,
		ST_NOT_RUNNING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_POP    = 2'd2
	} cell_op_t;

	typedef enum logic [1:0] {
		STK_HOLD = 2'd0,
		STK_PUSH = 2'd1,
		STK_POP  = 2'd2
	} stk_op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Control broadcast from the top level to every queue cell
	typedef struct packed {
		cell_op_t op;
		entry_t   new_entry;
	} cell_ctrl_t;

	typedef struct packed {
		func_t             func;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] task_priority;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               dispatched;
		logic [ID_W-1:0]    run_task_id;
		logic [RUN_W-1:0]   running_priority;
		logic [COUNT_W-1:0] queue_count;
	} rsp_t;

endpackage

/* rtl/ptq_chan_if.sv */
// Valid/ready channel carrying one payload of type T per transfer.
// Payload types come from ptq_pkg.
interface ptq_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/preemptive_priority_task_queue_top.sv */
// Top level of the preemptive priority task queue.
// Depends on ptq_pkg, ptq_chan_if, ptq_cell and ptq_stack_cell.
//
// Usage:
//   req (sink, ptq_pkg::req_t): func, task_id, task_priority. Add inserts a task
//   into a sorted queue (smaller priority first, ties in arrival order); dispatch
//   pops the head when it is strictly more urgent than the running priority and
//   the save stack has room, and pushes the running priority there; done pops it.
//   rsp (source, ptq_pkg::rsp_t): one result per request with status, dispatch
//   flag, dispatched id, running priority and queue count after the request.
// Result: registered, valid in the cycle after the request transfer.
// Throughput: one request per cycle while rsp.ready is high. Queue and stack are
//   rows of cells that all shift or hold together in the cycle of the transfer.
// Reset: queue and stack empty, running priority idle (256), no result pending.
//   Cell contents are not reset; only slots below the fill counts are read.
// Stall: while a result waits with rsp.ready low, req.ready drops; the
//   result and the state hold until the result is taken.
module preemptive_priority_task_queue_top #(
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF,
	parameter int NEST_DEPTH  = ptq_pkg::NEST_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ptq_chan_if.sink  req,
	ptq_chan_if.source rsp
);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SCNT_W = $clog2(NEST_DEPTH + 1);
	localparam int RUN_W  = ptq_pkg::RUN_W;

	logic [QCNT_W-1:0] fill_q, fill_n;
	logic [SCNT_W-1:0] depth_q, depth_n;
	logic [RUN_W-1:0]  cur_q, cur_n;
	logic              rsp_valid_q;
	ptq_pkg::rsp_t     rsp_q, rsp_n;

	ptq_pkg::cell_op_t   q_op;
	ptq_pkg::stk_op_t    s_op, s_op_g;
	ptq_pkg::cell_ctrl_t ctrl;
	ptq_pkg::entry_t     q_entry [QUEUE_DEPTH];
	logic                q_after [QUEUE_DEPTH];
	logic                q_occ   [QUEUE_DEPTH];
	logic [RUN_W-1:0]    s_value [NEST_DEPTH];

	logic accept, full, can_dispatch, can_done;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign full         = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign can_dispatch = (fill_q != '0)
		&& ({1'b0, q_entry[0].prio} < cur_q)
		&& (depth_q != SCNT_W'(NEST_DEPTH));
	assign can_done     = (depth_q != '0);

	always_comb begin
		q_op    = ptq_pkg::CELL_HOLD;
		s_op    = ptq_pkg::STK_HOLD;
		fill_n  = fill_q;
		depth_n = depth_q;
		cur_n   = cur_q;
		rsp_n   = '0;
		rsp_n.status = ptq_pkg::ST_OK;
		unique case (req.data.func)
			ptq_pkg::FN_ADD: begin
				if (full) begin
					rsp_n.status = ptq_pkg::ST_FULL;
				end else begin
					q_op   = ptq_pkg::CELL_INSERT;
					fill_n = fill_q + QCNT_W'(1);
				end
			end
			ptq_pkg::FN_DISPATCH: begin
				if (can_dispatch) begin
					q_op    = ptq_pkg::CELL_POP;
					s_op    = ptq_pkg::STK_PUSH;
					fill_n  = fill_q - QCNT_W'(1);
					depth_n = depth_q + SCNT_W'(1);
					cur_n   = {1'b0, q_entry[0].prio};
					rsp_n.dispatched  = 1'b1;
					rsp_n.run_task_id = q_entry[0].id;
				end else begin
					rsp_n.status = ptq_pkg::ST_NO_DISPATCH;
				end
			end
			ptq_pkg::FN_DONE: begin
				if (can_done) begin
					s_op    = ptq_pkg::STK_POP;
					depth_n = depth_q - SCNT_W'(1);
					cur_n   = s_value[0];
				end else begin
					rsp_n.status = ptq_pkg::ST_NOT_RUNNING;
				end
			end
			default: begin
			end
		endcase
		rsp_n.running_priority = cur_n;
		rsp_n.queue_count      = ptq_pkg::COUNT_W'(fill_n);
	end

	// Cells move only on a request transfer
	assign ctrl.op        = accept ? q_op : ptq_pkg::CELL_HOLD;
	assign ctrl.new_entry = '{id: req.data.task_id, prio: req.data.task_priority};
	assign s_op_g         = accept ? s_op : ptq_pkg::STK_HOLD;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
		ptq_pkg::entry_t left_w, right_w;
		logic            prev_w;

		assign q_occ[i] = (QCNT_W'(i) < fill_q);

		if (i == 0) begin : g_head
			assign left_w = ctrl.new_entry;
			assign prev_w = 1'b1;
		end else begin : g_body
			assign left_w = q_entry[i-1];
			assign prev_w = q_after[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_w = q_entry[i];
		end else begin : g_inner
			assign right_w = q_entry[i+1];
		end

		ptq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (q_occ[i]),
			.prev_after (prev_w),
			.left       (left_w),
			.right      (right_w),
			.entry      (q_entry[i]),
			.after      (q_after[i])
		);
	end

	for (genvar j = 0; j < NEST_DEPTH; j++) begin : g_stack
		logic [RUN_W-1:0] above_w, below_w;

		if (j == 0) begin : g_top
			assign above_w = cur_q;
		end else begin : g_body
			assign above_w = s_value[j-1];
		end

		if (j == NEST_DEPTH - 1) begin : g_bottom
			assign below_w = s_value[j];
		end else begin : g_inner
			assign below_w = s_value[j+1];
		end

		ptq_stack_cell u_scell (
			.clk   (clk),
			.op    (s_op_g),
			.above (above_w),
			.below (below_w),
			.value (s_value[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			depth_q     <= '0;
			cur_q       <= ptq_pkg::IDLE_PRIORITY;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_n;
				depth_q     <= depth_n;
				cur_q       <= cur_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_n;
		end
	end
endmodule

/* rtl/ptq_cell.sv */
// One slot of the sorted task queue; a row of these forms the queue.
// Depends on ptq_pkg for entry and control types.
module ptq_cell (
	input  logic                clk,
	input  ptq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                prev_after,
	input  ptq_pkg::entry_t     left,
	input  ptq_pkg::entry_t     right,
	output ptq_pkg::entry_t     entry,
	output logic                after
);
	ptq_pkg::entry_t entry_q;

	// New item goes behind this slot when the slot holds an equal or more urgent task
	assign after = occupied && (entry_q.prio <= ctrl.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ptq_pkg::CELL_INSERT: begin
				if (!after) begin
					entry_q <= prev_after ? ctrl.new_entry : left;
				end
			end
			ptq_pkg::CELL_POP: begin
				entry_q <= right;
			end
			default: begin
			end
		endcase
	end
endmodule

/* rtl/ptq_stack_cell.sv */
// One slot of the saved-priority stack; slot 0 is the top of the stack.
// Depends on ptq_pkg for the stack operation type and widths.
module ptq_stack_cell (
	input  logic                      clk,
	input  ptq_pkg::stk_op_t          op,
	input  logic [ptq_pkg::RUN_W-1:0] above,
	input  logic [ptq_pkg::RUN_W-1:0] below,
	output logic [ptq_pkg::RUN_W-1:0] value
);
	logic [ptq_pkg::RUN_W-1:0] value_q;

	assign value = value_q;

	always_ff @(posedge clk) begin
		case (op)
			ptq_pkg::STK_PUSH: value_q <= above;
			ptq_pkg::STK_POP:  value_q <= below;
			default: begin
			end
		endcase
	end
endmodule

/* rtl/ptq_checker.sv */
// Port-level checks for the preemptive priority task queue, bound to the top level.
// Depends on ptq_pkg and on preemptive_priority_task_queue_top.
module ptq_checker #(
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ptq_pkg::rsp_t rsp_data
);
	a_dispatch_runs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.dispatched |->
			rsp_data.status == ptq_pkg::ST_OK
			&& rsp_data.running_priority != ptq_pkg::IDLE_PRIORITY)
		else $error("dispatch result without ok status or with idle priority");

	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.dispatched |-> rsp_data.run_task_id == '0)
		else $error("task id shown without a dispatch");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ptq_pkg::ST_FULL |->
			rsp_data.queue_count == ptq_pkg::COUNT_W'(QUEUE_DEPTH))
		else $error("queue full reported below capacity");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.queue_count <= ptq_pkg::COUNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond capacity");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed or dropped");
endmodule

bind preemptive_priority_task_queue_top ptq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_ptq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
